// ===== rtl/wpa_pkg.sv =====
// wireframe primitive assembler package: topology codes, control struct, defaults
// used by every file of the block
package wpa_pkg;

   localparam int unsigned COORD_BITS_DEF = 12;
   localparam int unsigned TOPO_BITS      = 3;

   typedef enum logic [TOPO_BITS-1:0] {
      TOPO_TRIANGLES = 3'd0,
      TOPO_POINTS    = 3'd1,
      TOPO_LINES     = 3'd2,
      TOPO_STRIP     = 3'd3,
      TOPO_LOOP      = 3'd4,
      TOPO_TRI_STRIP = 3'd5,
      TOPO_TRI_FAN   = 3'd6
   } topo_type;

   // segments made by one vertex and whether the single one is a point
   typedef struct packed {
      logic [1:0] count;
      logic       is_point;
   } seg_ctl_type;

endpackage

// ===== rtl/wpa_vertex_if.sv =====
// vertex channel: valid/ready handshake with one screen vertex per transaction
// depends on wpa_pkg for the default coordinate width
interface wpa_vertex_if
   import wpa_pkg::*;
   #(parameter int unsigned COORD_BITS = COORD_BITS_DEF) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] vertex_x;
   logic signed [COORD_BITS-1:0] vertex_y;
   logic                         list_start;
   logic                         list_end;

   modport source (output valid, vertex_x, vertex_y, list_start, list_end, input ready);
   modport sink   (input valid, vertex_x, vertex_y, list_start, list_end, output ready);
endinterface

// ===== rtl/wpa_segment_if.sv =====
// segment channel: valid/ready handshake with one segment or point per transaction
// depends on wpa_pkg for the default coordinate width
interface wpa_segment_if
   import wpa_pkg::*;
   #(parameter int unsigned COORD_BITS = COORD_BITS_DEF) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   logic                         is_point;
   logic                         last_of_run;

   modport source (output valid, start_x, start_y, end_x, end_y, is_point, last_of_run,
                   input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, is_point, last_of_run,
                   output ready);
endinterface

// ===== rtl/wpa_edge_gen.sv =====
// edge generator: vertex history and list position, builds up to two segments per vertex
// depends on wpa_pkg
module wpa_edge_gen
   import wpa_pkg::*;
   #(parameter int unsigned COORD_BITS = COORD_BITS_DEF)
   (
   input  logic                      clock,
   input  logic                      reset,
   input  topo_type                  topology,
   input  logic                      accept,
   input  logic [COORD_BITS-1:0]     vertex_x,
   input  logic [COORD_BITS-1:0]     vertex_y,
   input  logic                      list_start,
   input  logic                      list_end,
   output logic [4*COORD_BITS-1:0]   seg0,
   output logic [4*COORD_BITS-1:0]   seg1,
   output seg_ctl_type               ctl
   );

   localparam int unsigned VB = 2 * COORD_BITS;

   logic [VB-1:0] first_ff, first_in;
   logic [VB-1:0] prev_ff, prev_in;
   logic [VB-1:0] prev2_ff, prev2_in;
   logic [1:0]    phase_ff, phase_in;
   logic [1:0]    seen_ff, seen_in;

   logic [VB-1:0] cur;
   logic [1:0]    n;
   logic [1:0]    ph;
   logic [1:0]    next_ph;

   assign cur = {vertex_x, vertex_y};

   always_comb begin
      n  = list_start ? 2'd0 : seen_ff;
      ph = (list_start || phase_ff == 2'd3) ? 2'd0 : phase_ff;
      seg0         = {prev_ff, cur};
      seg1         = {cur, prev2_ff};
      ctl.count    = 2'd0;
      ctl.is_point = 1'b0;
      next_ph      = 2'd0;
      unique case (topology)
         TOPO_TRIANGLES: begin
            ctl.count = (ph == 2'd0) ? 2'd0 : ph;
            next_ph   = (ph == 2'd2) ? 2'd0 : ph + 2'd1;
         end
         TOPO_POINTS: begin
            seg0         = {cur, cur};
            ctl.count    = 2'd1;
            ctl.is_point = 1'b1;
         end
         TOPO_LINES: begin
            ctl.count = (ph != 2'd0) ? 2'd1 : 2'd0;
            next_ph   = (ph != 2'd0) ? 2'd0 : 2'd1;
         end
         TOPO_STRIP: begin
            ctl.count = (n != 2'd0) ? 2'd1 : 2'd0;
         end
         TOPO_LOOP: begin
            seg1 = {cur, first_ff};
            if (n != 2'd0) begin
               ctl.count = list_end ? 2'd2 : 2'd1;
            end
         end
         TOPO_TRI_STRIP: begin
            ctl.count = (n >= 2'd2) ? 2'd2 : n;
         end
         TOPO_TRI_FAN: begin
            seg1      = {cur, first_ff};
            ctl.count = (n >= 2'd2) ? 2'd2 : n;
            if (n == 2'd3) begin
               seg0 = {cur, prev_ff};
            end
         end
         default: begin
            ctl.count = 2'd0;
         end
      endcase
   end

   always_comb begin
      first_in = first_ff;
      prev_in  = prev_ff;
      prev2_in = prev2_ff;
      phase_in = phase_ff;
      seen_in  = seen_ff;
      if (accept) begin
         if (n == 2'd0) begin
            first_in = cur;
         end
         prev2_in = prev_ff;
         prev_in  = cur;
         phase_in = next_ph;
         seen_in  = (n == 2'd3) ? 2'd3 : n + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         prev_ff  <= '0;
         prev2_ff <= '0;
         phase_ff <= 2'd0;
         seen_ff  <= 2'd0;
      end else begin
         first_ff <= first_in;
         prev_ff  <= prev_in;
         prev2_ff <= prev2_in;
         phase_ff <= phase_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

// ===== rtl/wpa_out_queue.sv =====
// two-slot result register: holds the segments of one vertex and hands them out in order
// depends on wpa_pkg
module wpa_out_queue
   import wpa_pkg::*;
   #(parameter int unsigned COORD_BITS = COORD_BITS_DEF)
   (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [4*COORD_BITS-1:0] seg0,
   input  logic [4*COORD_BITS-1:0] seg1,
   input  seg_ctl_type             ctl,
   output logic                    can_push,
   wpa_segment_if.source           rsp
   );

   localparam int unsigned SB = 4 * COORD_BITS;

   logic [SB-1:0] slot0_ff, slot0_in;
   logic [SB-1:0] slot1_ff, slot1_in;
   logic          point_ff, point_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          pop;

   assign pop      = rsp.valid && rsp.ready;
   assign can_push = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp.ready);

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      point_in = point_ff;
      cnt_in   = cnt_ff;
      priority if (push) begin
         slot0_in = seg0;
         slot1_in = seg1;
         point_in = ctl.is_point;
         cnt_in   = ctl.count;
      end else if (pop) begin
         slot0_in = slot1_ff;
         point_in = 1'b0;
         cnt_in   = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      point_ff <= point_in;
   end

   assign rsp.valid       = (cnt_ff != 2'd0);
   assign rsp.start_x     = slot0_ff[SB-1 -: COORD_BITS];
   assign rsp.start_y     = slot0_ff[SB-COORD_BITS-1 -: COORD_BITS];
   assign rsp.end_x       = slot0_ff[2*COORD_BITS-1 -: COORD_BITS];
   assign rsp.end_y       = slot0_ff[COORD_BITS-1:0];
   assign rsp.is_point    = point_ff;
   assign rsp.last_of_run = (cnt_ff == 2'd1);

endmodule

// ===== rtl/wireframe_primitive_assembler.sv =====
// wireframe primitive assembler top level: topology register, edge generator, result slots
// depends on wpa_pkg, wpa_vertex_if, wpa_segment_if, wpa_edge_gen, wpa_out_queue
//
// Vertices come in on req_bus and are turned into line segments or points on rsp_bus,
// following the topology held in the csr register (write with csr_write_en). A vertex
// that yields no segment or one segment is taken every cycle while rsp_bus is ready; a
// vertex with two segments (triangle close, loop close, triangle strip and fan) stalls
// req_bus until its first segment is taken: the output carries one segment per ready
// cycle from a two-slot result register. last_of_run marks each vertex's final segment.
// The user must change the topology only while idle; the block does not enforce it.
module wireframe_primitive_assembler
   import wpa_pkg::*;
   #(parameter int unsigned COORD_BITS = COORD_BITS_DEF)
   (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [TOPO_BITS-1:0] csr_write_data,
   wpa_vertex_if.sink           req_bus,
   wpa_segment_if.source        rsp_bus
   );

   topo_type                topology_ff, topology_in;
   logic                    accept;
   logic                    can_push;
   logic [4*COORD_BITS-1:0] seg0;
   logic [4*COORD_BITS-1:0] seg1;
   seg_ctl_type             ctl;

   assign topology_in   = csr_write_en ? topo_type'(csr_write_data) : topology_ff;
   assign req_bus.ready = can_push;
   assign accept        = req_bus.valid && can_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         topology_ff <= TOPO_TRIANGLES;
      end else begin
         topology_ff <= topology_in;
      end
   end

   wpa_edge_gen #(.COORD_BITS(COORD_BITS)) u_edge_gen (
      .clock      (clock),
      .reset      (reset),
      .topology   (topology_ff),
      .accept     (accept),
      .vertex_x   (req_bus.vertex_x),
      .vertex_y   (req_bus.vertex_y),
      .list_start (req_bus.list_start),
      .list_end   (req_bus.list_end),
      .seg0       (seg0),
      .seg1       (seg1),
      .ctl        (ctl)
   );

   wpa_out_queue #(.COORD_BITS(COORD_BITS)) u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .seg0     (seg0),
      .seg1     (seg1),
      .ctl      (ctl),
      .can_push (can_push),
      .rsp      (rsp_bus)
   );

   // a point vertex always shows up as a single point transaction next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept && topology_ff == TOPO_POINTS |=> rsp_bus.valid && rsp_bus.is_point
         && rsp_bus.last_of_run)
      else $error("point vertex did not give a point");

   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |-> !req_bus.ready)
      else $error("vertex taken while result stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.last_of_run && rsp_bus.ready |=> rsp_bus.valid)
      else $error("second segment of a vertex lost");

   assert property (@(posedge clock) disable iff (reset)
      accept && ctl.count == 2'd0 |=> !rsp_bus.valid)
      else $error("result shown for vertex without segments");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// testbench for wireframe_primitive_assembler: directed and random vertex lists
// depends on wpa_pkg, wpa_vertex_if, wpa_segment_if and the rtl of the block
module tb;
   import wpa_pkg::*;

   localparam int unsigned COORD_BITS      = COORD_BITS_DEF;
   localparam logic [TOPO_BITS-1:0] TOPO_UNDEFINED = 3'd7;
   localparam int          WATCHDOG_LIMIT  = 2000;
   localparam int          HOLD_OFF_CYCLES = 80;
   localparam int          SETTLE_CYCLES   = 4;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } vertex_type;

   typedef struct packed {
      vertex_type head;
      vertex_type tail;
      logic       is_point;
      logic       last_of_run;
   } segment_type;

   class segment_predictor;
      segment_type          expected_segments[$];
      segment_type          run_q[$];
      int                   errors;
      logic [TOPO_BITS-1:0] topology;
      vertex_type           first_vertex;
      vertex_type           prev_vertex;
      vertex_type           prev2_vertex;
      logic [1:0]           phase;
      logic [1:0]           seen_count;

      function new();
         errors       = 0;
         topology     = TOPO_TRIANGLES;
         first_vertex = '0;
         prev_vertex  = '0;
         prev2_vertex = '0;
         phase        = '0;
         seen_count   = '0;
      endfunction

      function void set_topology(logic [TOPO_BITS-1:0] value);
         topology = value;
      endfunction

      function int pending();
         return expected_segments.size();
      endfunction

      function segment_type make_segment(vertex_type a, vertex_type b, logic pt);
         segment_type s;
         s.head        = a;
         s.tail        = b;
         s.is_point    = pt;
         s.last_of_run = 1'b0;
         return s;
      endfunction

      function void add_segment(vertex_type a, vertex_type b, logic pt);
         run_q.insert(run_q.size(), make_segment(a, b, pt));
      endfunction

      function void note_vertex(vertex_type cur, logic list_start, logic list_end);
         int n;
         int ph;
         int next_ph;
         run_q.delete();
         n       = list_start ? 0 : int'(seen_count);
         ph      = list_start ? 0 : int'(phase);
         next_ph = 0;
         if (ph == 3) ph = 0;
         case (topology)
            TOPO_TRIANGLES: begin
               if (ph >= 1) add_segment(prev_vertex, cur, 1'b0);
               if (ph == 2) add_segment(cur, prev2_vertex, 1'b0);
               next_ph = (ph >= 2) ? 0 : ph + 1;
            end
            TOPO_POINTS: add_segment(cur, cur, 1'b1);
            TOPO_LINES: begin
               if (ph != 0) add_segment(prev_vertex, cur, 1'b0);
               next_ph = (ph != 0) ? 0 : 1;
            end
            TOPO_STRIP: begin
               if (n >= 1) add_segment(prev_vertex, cur, 1'b0);
            end
            TOPO_LOOP: begin
               if (n >= 1) begin
                  add_segment(prev_vertex, cur, 1'b0);
                  if (list_end) add_segment(cur, first_vertex, 1'b0);
               end
            end
            TOPO_TRI_STRIP: begin
               if (n >= 1) add_segment(prev_vertex, cur, 1'b0);
               if (n >= 2) add_segment(cur, prev2_vertex, 1'b0);
            end
            TOPO_TRI_FAN: begin
               if (n == 1 || n == 2) add_segment(prev_vertex, cur, 1'b0);
               else if (n >= 3) add_segment(cur, prev_vertex, 1'b0);
               if (n >= 2) add_segment(cur, first_vertex, 1'b0);
            end
            default: ;
         endcase
         if (run_q.size() > 0) run_q[run_q.size()-1].last_of_run = 1'b1;
         foreach (run_q[i]) expected_segments.insert(expected_segments.size(), run_q[i]);
         if (n == 0) first_vertex = cur;
         prev2_vertex = prev_vertex;
         prev_vertex  = cur;
         phase        = next_ph[1:0];
         seen_count   = (n >= 3) ? 2'd3 : 2'(n + 1);
      endfunction

      function void check_segment(segment_type got);
         segment_type want;
         if (expected_segments.size() == 0) begin
            errors++;
            $display("%0t: unexpected segment (%0d,%0d)-(%0d,%0d) pt %0b last %0b", $time,
                     got.head.x, got.head.y, got.tail.x, got.tail.y,
                     got.is_point, got.last_of_run);
            return;
         end
         want = expected_segments.pop_front();
         if (got.head.x !== want.head.x || got.head.y !== want.head.y ||
             got.tail.x !== want.tail.x || got.tail.y !== want.tail.y ||
             got.is_point !== want.is_point || got.last_of_run !== want.last_of_run) begin
            errors++;
            $display({"%0t: mismatch expected (%0d,%0d)-(%0d,%0d) pt %0b last %0b,",
                      " actual (%0d,%0d)-(%0d,%0d) pt %0b last %0b"},
                     $time, want.head.x, want.head.y, want.tail.x, want.tail.y,
                     want.is_point, want.last_of_run, got.head.x, got.head.y,
                     got.tail.x, got.tail.y, got.is_point, got.last_of_run);
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [TOPO_BITS-1:0] csr_write_data;

   wpa_vertex_if  #(.COORD_BITS(COORD_BITS)) req_if ();
   wpa_segment_if #(.COORD_BITS(COORD_BITS)) rsp_if ();

   wireframe_primitive_assembler #(.COORD_BITS(COORD_BITS)) u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_bus        (req_if),
      .rsp_bus        (rsp_if)
   );

   segment_predictor sb = new();
   int send_idle;
   int recv_idle;
   bit hold_req;
   int hold_left;
   int idle_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side: check accepted transactions, random ready, one long hold-off on request
   initial begin
      rsp_if.ready = 1'b0;
      hold_left    = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            sb.check_segment({rsp_if.start_x, rsp_if.start_y, rsp_if.end_x, rsp_if.end_y,
                              rsp_if.is_point, rsp_if.last_of_run});
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   function automatic int rand_coord();
      case ($urandom_range(7))
         0:       return -2048;
         1:       return 2047;
         default: return int'($urandom_range(4095)) - 2048;
      endcase
   endfunction

   task automatic put_vertex(input int x, input int y, input bit list_start, input bit list_end);
      vertex_type v;
      v.x = x[COORD_BITS-1:0];
      v.y = y[COORD_BITS-1:0];
      while ($urandom_range(99) < send_idle) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.vertex_x   <= v.x;
      req_if.vertex_y   <= v.y;
      req_if.list_start <= list_start;
      req_if.list_end   <= list_end;
      do @(posedge clock); while (!req_if.ready);
      sb.note_vertex(v, list_start, list_end);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_topology(input logic [TOPO_BITS-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      sb.set_topology(value);
      csr_write_en <= 1'b0;
   endtask

   task automatic send_list(input int len);
      bit s;
      bit e;
      for (int i = 0; i < len; i++) begin
         s = (i == 0);
         e = (i == len - 1);
         // occasional broken markers
         if ($urandom_range(9) == 0) s = 1'($urandom_range(1));
         if ($urandom_range(9) == 0) e = 1'($urandom_range(1));
         put_vertex(rand_coord(), rand_coord(), s, e);
      end
   endtask

   task automatic random_phase(input int n_items);
      int sent;
      int len;
      logic [TOPO_BITS-1:0] topo;
      sent = 0;
      while (sent < n_items) begin
         topo = TOPO_BITS'($urandom_range(6));
         if ($urandom_range(15) == 0) topo = TOPO_UNDEFINED;
         wait_idle();
         write_topology(topo);
         repeat ($urandom_range(3, 1)) begin
            len = int'($urandom_range(8, 1));
            send_list(len);
            if (topo != TOPO_UNDEFINED) sent += len;
         end
      end
   endtask

   initial begin
      reset             = 1'b1;
      csr_write_en      = 1'b0;
      csr_write_data    = '0;
      req_if.valid      = 1'b0;
      req_if.vertex_x   = '0;
      req_if.vertex_y   = '0;
      req_if.list_start = 1'b0;
      req_if.list_end   = 1'b0;
      hold_req          = 1'b0;
      send_idle         = 9;
      recv_idle         = 81;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // list begins at reset, triangles by default
      put_vertex(-2048, -2048, 1'b0, 1'b0);
      put_vertex(2047, 2047, 1'b0, 1'b0);
      put_vertex(-2048, 2047, 1'b0, 1'b0);
      put_vertex(2047, -2048, 1'b0, 1'b0);
      // lines picking up a triangle phase mid-list
      wait_idle();
      write_topology(TOPO_LINES);
      put_vertex(0, -1, 1'b0, 1'b0);
      put_vertex(-1, 0, 1'b0, 1'b0);
      put_vertex(1365, -1366, 1'b0, 1'b1);
      wait_idle();
      write_topology(TOPO_POINTS);
      put_vertex(-2048, 2047, 1'b1, 1'b1);
      put_vertex(2047, -2048, 1'b0, 1'b0);
      wait_idle();
      write_topology(TOPO_STRIP);
      put_vertex(10, 20, 1'b1, 1'b0);
      put_vertex(-30, 40, 1'b0, 1'b0);
      put_vertex(50, -60, 1'b0, 1'b1);
      // single-vertex loop, then a closed loop
      wait_idle();
      write_topology(TOPO_LOOP);
      put_vertex(7, 7, 1'b1, 1'b1);
      put_vertex(-2048, 0, 1'b1, 1'b0);
      put_vertex(0, 2047, 1'b0, 1'b0);
      put_vertex(2047, 0, 1'b0, 1'b1);
      wait_idle();
      write_topology(TOPO_TRI_STRIP);
      put_vertex(1, 2, 1'b1, 1'b0);
      put_vertex(3, 4, 1'b0, 1'b0);
      put_vertex(5, 6, 1'b0, 1'b0);
      put_vertex(7, 8, 1'b0, 1'b1);
      wait_idle();
      write_topology(TOPO_TRI_FAN);
      put_vertex(-100, -100, 1'b1, 1'b0);
      put_vertex(100, -100, 1'b0, 1'b0);
      put_vertex(100, 100, 1'b0, 1'b0);
      put_vertex(-100, 100, 1'b0, 1'b1);
      wait_idle();
      write_topology(TOPO_UNDEFINED);
      put_vertex(123, -456, 1'b1, 1'b0);
      put_vertex(-789, 321, 1'b0, 1'b1);

      random_phase(20);
      send_idle = 81;
      recv_idle = 9;
      random_phase(20);
      send_idle = 0;
      recv_idle = 0;
      // long receiver hold-off while the fan keeps producing
      wait_idle();
      write_topology(TOPO_TRI_FAN);
      hold_req = 1'b1;
      send_list(10);
      random_phase(14);

      wait_idle();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
